[src/rcppm_pkg.sv]
// ============================================================================
// rcppm_pkg
// Shared types, constants and arithmetic helpers for the pulse-position
// channel decoder.
// ============================================================================
`default_nettype none

package rcppm_pkg;

    // Frame geometry
    localparam int CHANNELS       = 7;
    localparam int RANGE_CHANNELS = 5;   // channels checked before outputs update
    localparam int STEP_W         = 3;   // eight-step sequencer
    localparam int TIME_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int CTR_W          = 9;   // centered value, signed

    // Valid width: upper byte must be exactly one (256..511)
    localparam logic [BYTE_W-1:0] WIDTH_HI_OK = 8'd1;

    // Event codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_ON_THIRD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ROLL_PITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_RATE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_PULSES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP_TICKS    = 3'd6;

    // Register reset values
    localparam logic [BYTE_W-1:0] NEUTRAL_RST    = 8'd128;
    localparam logic [TIME_W-1:0] SHORT_GAP_RST  = 16'd78;
    localparam logic [TIME_W-1:0] LONG_GAP_RST   = 16'd219;

    // Stick mapping controls handed to the frame mapper
    typedef struct packed {
        logic [BYTE_W-1:0] neutral;
        logic              throttle_on_third;
        logic              swap_roll_pitch;
        logic              double_rate;
    } rcppm_map_cfg_t;

    // Half of the modular difference, arithmetic shift keeps bit 15
    function automatic logic [TIME_W-1:0] half_width(
        input logic [TIME_W-1:0] later,
        input logic [TIME_W-1:0] earlier
    );
        logic [TIME_W-1:0] d;
        begin
            d = later - earlier;
            return {d[TIME_W-1], d[TIME_W-1:1]};
        end
    endfunction

    // Low byte minus neutral, signed
    function automatic logic signed [CTR_W-1:0] centred(
        input logic [BYTE_W-1:0] w,
        input logic [BYTE_W-1:0] neutral
    );
        begin
            return $signed({1'b0, w}) - $signed({1'b0, neutral});
        end
    endfunction

    // Halve, rounding toward zero
    function automatic logic signed [CTR_W-1:0] halve(
        input logic signed [CTR_W-1:0] v
    );
        logic signed [CTR_W-1:0] t;
        begin
            t = v + $signed({{(CTR_W-1){1'b0}}, v[CTR_W-1]});
            return t >>> 1;
        end
    endfunction

endpackage

`default_nettype wire

[src/rc_ppm_channel_decoder.sv]
// ============================================================================
// rc_ppm_channel_decoder
// Decodes a radio-control pulse-position train from edge and tick events.
// Each accepted request is either a captured edge (cmd = edge, with its 16-bit
// timestamp) or a gap timer tick, and yields exactly one response carrying
// the current channel values and the lost / fresh flags. Edges alternate in
// polarity and walk an eight-step sequencer; when channel five closes the
// first five widths are range checked and the sticks are remapped. A short
// gap resynchronizes the sequencer and a following long gap flags signal
// loss. One request is taken every clock while the response side is not stalled;
// its response is offered after the input register and then the state update
// that also forms the response register. A single state update per event sets
// the rate. Configuration is written through a plain indexed write port, by
// the user only while the decoder is idle; the block does not enforce this.
// ============================================================================
`default_nettype none

module rc_ppm_channel_decoder (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Configuration
    input  wire logic                                   cfg_wr_en,
    input  wire logic [rcppm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rcppm_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Request channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   cmd,
    input  wire logic [rcppm_pkg::TIME_W-1:0]           capture_time,
    // Response channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [rcppm_pkg::BYTE_W-1:0]                throttle,
    output logic signed [rcppm_pkg::CTR_W-1:0]          roll,
    output logic signed [rcppm_pkg::CTR_W-1:0]          pitch,
    output logic signed [rcppm_pkg::CTR_W-1:0]          yaw,
    output logic [rcppm_pkg::BYTE_W-1:0]                aux_five,
    output logic [rcppm_pkg::BYTE_W-1:0]                aux_six,
    output logic [rcppm_pkg::BYTE_W-1:0]                aux_seven,
    output logic                                        signal_lost,
    output logic                                        fresh_frame
);
    import rcppm_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] neutral_reg;
    logic              thr_third_reg;
    logic              swap_rp_reg;
    logic              dbl_rate_reg;
    logic              neg_pulse_reg;
    logic [TIME_W-1:0] short_gap_reg;
    logic [TIME_W-1:0] long_gap_reg;

    // Input stage
    logic              in_vld_reg;
    logic              in_cmd_reg;
    logic [TIME_W-1:0] in_time_reg;

    // Decoder state
    logic [TIME_W-1:0] stamps_reg [CHANNELS];
    logic [TIME_W-1:0] stamps_next [CHANNELS];
    logic [STEP_W-1:0] step_reg, step_next;
    logic              phase_reg, phase_next;
    logic              gap_seen_reg, gap_seen_next;
    logic              long_act_reg, long_act_next;
    logic [TIME_W-1:0] gap_cnt_reg, gap_cnt_next;
    logic [BYTE_W-1:0] thr_reg, thr_next;
    logic signed [CTR_W-1:0] roll_reg, roll_next;
    logic signed [CTR_W-1:0] pitch_reg, pitch_next;
    logic signed [CTR_W-1:0] yaw_reg, yaw_next;
    logic [BYTE_W-1:0] aux5_reg, aux5_next;
    logic [BYTE_W-1:0] aux6_reg, aux6_next;
    logic [BYTE_W-1:0] aux7_reg, aux7_next;
    logic              lost_reg, lost_next;
    logic              fresh_reg, fresh_next;
    logic              out_vld_reg;

    // Handshake and datapath nets
    logic              out_free;
    logic              process;
    logic [STEP_W-1:0] prev_idx;
    logic [TIME_W-1:0] hw;
    logic [TIME_W-1:0] cnt_inc;
    logic [TIME_W-1:0] gap_limit;
    logic              phase_tog;
    logic              leading;
    logic              err;

    rcppm_map_cfg_t          map_cfg;
    logic [TIME_W-1:0]       fm_widths [RANGE_CHANNELS];
    logic                    fm_ok;
    logic [BYTE_W-1:0]       fm_thr;
    logic signed [CTR_W-1:0] fm_roll;
    logic signed [CTR_W-1:0] fm_pitch;
    logic signed [CTR_W-1:0] fm_yaw;
    logic [BYTE_W-1:0]       fm_aux5;

    // ------------------------------------------------------------------
    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_reg   <= NEUTRAL_RST;
            thr_third_reg <= 1'b0;
            swap_rp_reg   <= 1'b0;
            dbl_rate_reg  <= 1'b0;
            neg_pulse_reg <= 1'b0;
            short_gap_reg <= SHORT_GAP_RST;
            long_gap_reg  <= LONG_GAP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_NEUTRAL_OFFSET:    neutral_reg   <= cfg_data[BYTE_W-1:0];
                CFG_THROTTLE_ON_THIRD: thr_third_reg <= cfg_data[0];
                CFG_SWAP_ROLL_PITCH:   swap_rp_reg   <= cfg_data[0];
                CFG_DOUBLE_RATE:       dbl_rate_reg  <= cfg_data[0];
                CFG_NEGATIVE_PULSES:   neg_pulse_reg <= cfg_data[0];
                CFG_SHORT_GAP_TICKS:   short_gap_reg <= cfg_data[TIME_W-1:0];
                CFG_LONG_GAP_TICKS:    long_gap_reg  <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the state registers double as the response register
    assign out_free = !out_vld_reg || out_ready;
    assign process  = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_cmd_reg  <= cmd;
            in_time_reg <= capture_time;
        end
    end

    // Response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Width of the channel that closes at this edge
    assign prev_idx = (step_reg == '0) ? '0 : step_reg - STEP_W'(1);
    assign hw       = half_width(in_time_reg, stamps_reg[prev_idx]);

    // Gap timer
    assign gap_limit = long_act_reg ? long_gap_reg : short_gap_reg;
    assign cnt_inc   = gap_cnt_reg + TIME_W'(1);

    // Edge polarity
    assign phase_tog = ~phase_reg;
    assign leading   = neg_pulse_reg ^ phase_tog;

    // Frame mapper sees channels one to four plus the width closing now
    assign map_cfg.neutral           = neutral_reg;
    assign map_cfg.throttle_on_third = thr_third_reg;
    assign map_cfg.swap_roll_pitch   = swap_rp_reg;
    assign map_cfg.double_rate       = dbl_rate_reg;

    always_comb
    begin
        for (int i = 0; i < RANGE_CHANNELS - 1; i++)
        begin
            fm_widths[i] = stamps_reg[i];
        end
        fm_widths[RANGE_CHANNELS-1] = hw;
    end

    rcppm_frame_map u_frame_map (
        .cfg      (map_cfg),
        .widths   (fm_widths),
        .frame_ok (fm_ok),
        .throttle (fm_thr),
        .roll     (fm_roll),
        .pitch    (fm_pitch),
        .yaw      (fm_yaw),
        .aux_five (fm_aux5)
    );

    // ------------------------------------------------------------------
    // Sequencer next state
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            stamps_next[i] = stamps_reg[i];
        end
        step_next     = step_reg;
        phase_next    = phase_reg;
        gap_seen_next = gap_seen_reg;
        long_act_next = long_act_reg;
        gap_cnt_next  = gap_cnt_reg;
        thr_next      = thr_reg;
        roll_next     = roll_reg;
        pitch_next    = pitch_reg;
        yaw_next      = yaw_reg;
        aux5_next     = aux5_reg;
        aux6_next     = aux6_reg;
        aux7_next     = aux7_reg;
        lost_next     = lost_reg;
        fresh_next    = fresh_reg;
        err           = 1'b0;

        if (process)
        begin
            if (in_cmd_reg == CMD_TICK)
            begin
                // Gap timer tick
                if (cnt_inc < gap_limit)
                begin
                    gap_cnt_next = cnt_inc;
                end
                else
                begin
                    gap_cnt_next = '0;
                    step_next    = '0;
                    if (gap_seen_reg)
                    begin
                        // second timeout: signal lost
                        long_act_next = 1'b0;
                        lost_next     = 1'b1;
                        fresh_next    = 1'b0;
                        phase_next    = neg_pulse_reg;
                    end
                    else
                    begin
                        gap_seen_next = 1'b1;
                        long_act_next = 1'b1;
                    end
                end
            end
            else
            begin
                // Captured edge
                gap_cnt_next  = '0;
                gap_seen_next = 1'b0;
                long_act_next = 1'b0;
                phase_next    = phase_tog;
                step_next     = step_reg + STEP_W'(1);

                if (leading)
                begin
                    if (step_reg[0])
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        stamps_next[step_reg] = in_time_reg;
                        if (step_reg != '0)
                        begin
                            stamps_next[prev_idx] = hw;
                        end
                        if (step_reg == STEP_W'(6))
                        begin
                            aux6_next = hw[BYTE_W-1:0];
                        end
                    end
                end
                else
                begin
                    if (!step_reg[0])
                    begin
                        err = 1'b1;
                    end
                    else if (step_reg == STEP_W'(7))
                    begin
                        stamps_next[CHANNELS-1] = hw;
                        aux7_next = hw[BYTE_W-1:0];
                    end
                    else
                    begin
                        stamps_next[step_reg] = in_time_reg;
                        stamps_next[prev_idx] = hw;
                        // channel five closes: check and map the frame
                        if (step_reg == STEP_W'(5))
                        begin
                            if (fm_ok)
                            begin
                                thr_next   = fm_thr;
                                roll_next  = fm_roll;
                                pitch_next = fm_pitch;
                                yaw_next   = fm_yaw;
                                aux5_next  = fm_aux5;
                                lost_next  = 1'b0;
                                fresh_next = 1'b1;
                            end
                            else
                            begin
                                err = 1'b1;
                            end
                        end
                    end
                end

                // Error restart: polarity mismatch or bad frame
                if (err)
                begin
                    lost_next  = 1'b1;
                    fresh_next = 1'b0;
                    step_next  = '0;
                    phase_next = neg_pulse_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                stamps_reg[i] <= '0;
            end
            step_reg     <= '0;
            phase_reg    <= 1'b0;
            gap_seen_reg <= 1'b0;
            long_act_reg <= 1'b0;
            gap_cnt_reg  <= '0;
            thr_reg      <= '0;
            roll_reg     <= '0;
            pitch_reg    <= '0;
            yaw_reg      <= '0;
            aux5_reg     <= '0;
            aux6_reg     <= '0;
            aux7_reg     <= '0;
            lost_reg     <= 1'b1;
            fresh_reg    <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                stamps_reg[i] <= stamps_next[i];
            end
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            gap_seen_reg <= gap_seen_next;
            long_act_reg <= long_act_next;
            gap_cnt_reg  <= gap_cnt_next;
            thr_reg      <= thr_next;
            roll_reg     <= roll_next;
            pitch_reg    <= pitch_next;
            yaw_reg      <= yaw_next;
            aux5_reg     <= aux5_next;
            aux6_reg     <= aux6_next;
            aux7_reg     <= aux7_next;
            lost_reg     <= lost_next;
            fresh_reg    <= fresh_next;
        end
    end

    // ------------------------------------------------------------------
    // Response
    assign out_valid   = out_vld_reg;
    assign throttle    = thr_reg;
    assign roll        = roll_reg;
    assign pitch       = pitch_reg;
    assign yaw         = yaw_reg;
    assign aux_five    = aux5_reg;
    assign aux_six     = aux6_reg;
    assign aux_seven   = aux7_reg;
    assign signal_lost = lost_reg;
    assign fresh_frame = fresh_reg;

endmodule

`default_nettype wire

[src/rcppm_frame_map.sv]
// ============================================================================
// rcppm_frame_map
// Range check of the first five channel widths and stick mapping into
// throttle, roll, pitch, yaw and channel five.
// ============================================================================
`default_nettype none

module rcppm_frame_map (
    input  wire rcppm_pkg::rcppm_map_cfg_t cfg,
    input  wire logic [rcppm_pkg::TIME_W-1:0]
                    widths [rcppm_pkg::RANGE_CHANNELS],
    output logic                               frame_ok,
    output logic [rcppm_pkg::BYTE_W-1:0]       throttle,
    output logic signed [rcppm_pkg::CTR_W-1:0] roll,
    output logic signed [rcppm_pkg::CTR_W-1:0] pitch,
    output logic signed [rcppm_pkg::CTR_W-1:0] yaw,
    output logic [rcppm_pkg::BYTE_W-1:0]       aux_five
);
    import rcppm_pkg::*;

    logic signed [CTR_W-1:0] roll_raw;
    logic signed [CTR_W-1:0] pitch_raw;

    // All checked widths must sit in 256..511
    always_comb
    begin
        frame_ok = 1'b1;
        for (int i = 0; i < RANGE_CHANNELS; i++)
        begin
            if (widths[i][TIME_W-1:BYTE_W] != WIDTH_HI_OK)
            begin
                frame_ok = 1'b0;
            end
        end
    end

    // Source selection by stick mode
    always_comb
    begin
        if (cfg.throttle_on_third)
        begin
            throttle = widths[2][BYTE_W-1:0];
            if (cfg.swap_roll_pitch)
            begin
                roll_raw  = centred(widths[1][BYTE_W-1:0], cfg.neutral);
                pitch_raw = centred(widths[0][BYTE_W-1:0], cfg.neutral);
            end
            else
            begin
                roll_raw  = centred(widths[0][BYTE_W-1:0], cfg.neutral);
                pitch_raw = centred(widths[1][BYTE_W-1:0], cfg.neutral);
            end
        end
        else
        begin
            throttle  = widths[0][BYTE_W-1:0];
            roll_raw  = centred(widths[1][BYTE_W-1:0], cfg.neutral);
            pitch_raw = centred(widths[2][BYTE_W-1:0], cfg.neutral);
        end
    end

    // Optional double-rate halving on roll and pitch
    always_comb
    begin
        if (cfg.double_rate)
        begin
            roll  = halve(roll_raw);
            pitch = halve(pitch_raw);
        end
        else
        begin
            roll  = roll_raw;
            pitch = pitch_raw;
        end
    end

    assign yaw      = centred(widths[3][BYTE_W-1:0], cfg.neutral);
    assign aux_five = widths[4][BYTE_W-1:0];

endmodule

`default_nettype wire

[bench/tb_rc_ppm_channel_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_rc_ppm_channel_decoder
// Self-checking bench for the pulse-position channel decoder. Edge and tick
// requests go in with random gaps. Every response is checked field by field
// against a local model of the sequencer, the range check and the stick
// mapping. The run starts with directed frames, range limits, gap timeouts
// and polarity faults. It then covers the gap limit extremes at full rate,
// and finally random traffic under several mapping and polarity settings.
// ============================================================================

module tb_rc_ppm_channel_decoder;
    import rcppm_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 4;     // idle wait after the last response

    // One response as the decoder presents it
    typedef struct packed {
        logic [BYTE_W-1:0] throttle;
        logic [CTR_W-1:0]  roll;
        logic [CTR_W-1:0]  pitch;
        logic [CTR_W-1:0]  yaw;
        logic [BYTE_W-1:0] aux_five;
        logic [BYTE_W-1:0] aux_six;
        logic [BYTE_W-1:0] aux_seven;
        logic              signal_lost;
        logic              fresh_frame;
    } stick_report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [TIME_W-1:0]      capture_time;
    logic                   out_valid;
    logic                   out_ready;
    logic [BYTE_W-1:0]      throttle;
    logic signed [CTR_W-1:0] roll;
    logic signed [CTR_W-1:0] pitch;
    logic signed [CTR_W-1:0] yaw;
    logic [BYTE_W-1:0]      aux_five;
    logic [BYTE_W-1:0]      aux_six;
    logic [BYTE_W-1:0]      aux_seven;
    logic                   signal_lost;
    logic                   fresh_frame;

    // Decoder model state
    logic [TIME_W-1:0]      pulse_span [CHANNELS];
    logic [STEP_W-1:0]      seq_step;
    logic                   seq_phase;
    logic                   gap_armed;
    logic                   gap_long;
    logic [TIME_W-1:0]      gap_ticks;
    stick_report_t          held;

    // Model copy of the registers
    logic [BYTE_W-1:0]      cfg_neutral;
    logic                   cfg_third;
    logic                   cfg_swap;
    logic                   cfg_dbl;
    logic                   cfg_neg;
    logic [TIME_W-1:0]      cfg_short;
    logic [TIME_W-1:0]      cfg_long;

    stick_report_t          reports_due [$];
    logic [TIME_W-1:0]      train_clock;
    int                     events_posted = 0;
    int                     mismatches = 0;
    int                     quiet_cycles = 0;
    int                     calm_left [2] = '{0, 0};
    logic                   full_rate = 1'b0;

    rc_ppm_channel_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .capture_time (capture_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .throttle     (throttle),
        .roll         (roll),
        .pitch        (pitch),
        .yaw          (yaw),
        .aux_five     (aux_five),
        .aux_six      (aux_six),
        .aux_seven    (aux_seven),
        .signal_lost  (signal_lost),
        .fresh_frame  (fresh_frame)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------

    // Half of the wrapped timestamp difference, sign bit kept
    function automatic logic [TIME_W-1:0] halved_span(input logic [TIME_W-1:0] later,
                                                      input logic [TIME_W-1:0] earlier);
        logic signed [TIME_W-1:0] diff;
        diff = later - earlier;
        return diff >>> 1;
    endfunction

    // Low byte minus neutral, optionally halved toward zero
    function automatic logic [CTR_W-1:0] stick_offset(input logic [TIME_W-1:0] w,
                                                      input logic halve_it);
        int v;
        v = int'(w[BYTE_W-1:0]);
        v = v - int'(cfg_neutral);
        if (halve_it)
            v = v / 2;
        return v[CTR_W-1:0];
    endfunction

    // Bad frame, polarity fault or long gap: drop back to the first step
    task automatic sync_lost();
        held.fresh_frame = 1'b0;
        held.signal_lost = 1'b1;
        seq_step  = '1;
        seq_phase = cfg_neg;
    endtask

    // Advance the model by one request and queue the response it implies
    task automatic decode_event(input logic ev, input logic [TIME_W-1:0] t);
        logic [STEP_W-1:0] s;
        logic [TIME_W-1:0] lim;
        logic [TIME_W-1:0] thr_src;
        logic [TIME_W-1:0] r_src;
        logic [TIME_W-1:0] p_src;
        logic              in_band;
        s = seq_step;
        if (ev == CMD_TICK)
        begin
            lim = gap_long ? cfg_long : cfg_short;
            gap_ticks = gap_ticks + 1'b1;
            if (gap_ticks >= lim)
            begin
                gap_ticks = '0;
                if (gap_armed)
                begin
                    // second timeout: signal lost
                    gap_long = 1'b0;
                    sync_lost();
                    seq_step = '0;
                end
                else
                begin
                    // first timeout: resync, arm the long limit
                    gap_armed = 1'b1;
                    gap_long  = 1'b1;
                    seq_step  = '0;
                end
            end
        end
        else
        begin
            gap_ticks = '0;
            gap_armed = 1'b0;
            gap_long  = 1'b0;
            seq_phase = ~seq_phase;
            if (cfg_neg ^ seq_phase)
            begin
                // leading edge, serves even steps
                if (s[0])
                    sync_lost();
                else
                begin
                    pulse_span[s] = t;
                    if (s != 0)
                    begin
                        pulse_span[s - 1'b1] = halved_span(t, pulse_span[s - 1'b1]);
                        if (s == 6)
                            held.aux_six = pulse_span[5][BYTE_W-1:0];
                    end
                end
            end
            else
            begin
                // trailing edge, serves odd steps
                if (!s[0])
                    sync_lost();
                else if (s == 7)
                begin
                    pulse_span[6] = halved_span(t, pulse_span[6]);
                    held.aux_seven = pulse_span[6][BYTE_W-1:0];
                end
                else
                begin
                    pulse_span[s] = t;
                    pulse_span[s - 1'b1] = halved_span(t, pulse_span[s - 1'b1]);
                    if (s == 5)
                    begin
                        // channel five closed: range check, then stick mapping
                        in_band = 1'b1;
                        for (int i = 0; i < RANGE_CHANNELS; i++)
                            if (pulse_span[i][TIME_W-1:BYTE_W] != WIDTH_HI_OK)
                                in_band = 1'b0;
                        if (!in_band)
                            sync_lost();
                        else
                        begin
                            if (cfg_third)
                            begin
                                thr_src = pulse_span[2];
                                r_src   = cfg_swap ? pulse_span[1] : pulse_span[0];
                                p_src   = cfg_swap ? pulse_span[0] : pulse_span[1];
                            end
                            else
                            begin
                                thr_src = pulse_span[0];
                                r_src   = pulse_span[1];
                                p_src   = pulse_span[2];
                            end
                            held.throttle    = thr_src[BYTE_W-1:0];
                            held.roll        = stick_offset(r_src, cfg_dbl);
                            held.pitch       = stick_offset(p_src, cfg_dbl);
                            held.yaw         = stick_offset(pulse_span[3], 1'b0);
                            held.aux_five    = pulse_span[4][BYTE_W-1:0];
                            held.signal_lost = 1'b0;
                            held.fresh_frame = 1'b1;
                        end
                    end
                end
            end
            seq_step = seq_step + 1'b1;
        end
        reports_due.push_back(held);
    endtask

    // ------------------------------------------------------------------
    // Request and response sides
    // ------------------------------------------------------------------

    // Wait before the next request (side 0) or response (side 1)
    function automatic int draw_wait(input int side);
        if (full_rate)
            return 0;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(19, 0) == 0)
        begin
            calm_left[side] = $urandom_range(30, 8);
            return 0;
        end
        return $urandom_range(14, 0);
    endfunction

    // Send one request; valid stays up after acceptance until the next call
    task automatic post_event(input logic ev, input logic [TIME_W-1:0] t);
        int gap;
        gap = draw_wait(0);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        cmd          = ev;
        capture_time = t;
        do @(posedge clk); while (!in_ready);
        decode_event(ev, t);
        events_posted++;
        @(negedge clk);
    endtask

    task automatic post_edge(input logic [TIME_W-1:0] span);
        train_clock = train_clock + span;
        post_event(CMD_EDGE, train_clock);
    endtask

    task automatic post_tick();
        post_event(CMD_TICK, TIME_W'($urandom_range(65535, 0)));
    endtask

    // Wait until every response is back, with the input side idle
    task automatic quiesce();
        in_valid = 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        quiesce();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_NEUTRAL_OFFSET:    cfg_neutral = val[BYTE_W-1:0];
            CFG_THROTTLE_ON_THIRD: cfg_third   = val[0];
            CFG_SWAP_ROLL_PITCH:   cfg_swap    = val[0];
            CFG_DOUBLE_RATE:       cfg_dbl     = val[0];
            CFG_NEGATIVE_PULSES:   cfg_neg     = val[0];
            CFG_SHORT_GAP_TICKS:   cfg_short   = val;
            CFG_LONG_GAP_TICKS:    cfg_long    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] neutral, input logic third,
                                  input logic swap, input logic dbl, input logic neg,
                                  input logic [TIME_W-1:0] short_lim,
                                  input logic [TIME_W-1:0] long_lim);
        write_reg(CFG_NEUTRAL_OFFSET, CFG_DATA_W'(neutral));
        write_reg(CFG_THROTTLE_ON_THIRD, CFG_DATA_W'(third));
        write_reg(CFG_SWAP_ROLL_PITCH, CFG_DATA_W'(swap));
        write_reg(CFG_DOUBLE_RATE, CFG_DATA_W'(dbl));
        write_reg(CFG_NEGATIVE_PULSES, CFG_DATA_W'(neg));
        write_reg(CFG_SHORT_GAP_TICKS, short_lim);
        write_reg(CFG_LONG_GAP_TICKS, long_lim);
    endtask

    // ------------------------------------------------------------------
    // Pulse train generation
    // ------------------------------------------------------------------

    // Timestamp difference giving an in-range width (256..511) or not
    function automatic logic [TIME_W-1:0] pick_span(input logic in_band);
        if (in_band)
            return TIME_W'($urandom_range(1023, 512));
        if ($urandom_range(1, 0))
            return TIME_W'($urandom_range(511, 0));
        return TIME_W'($urandom_range(65535, 1024));
    endfunction

    // Feed edges until the sequencer waits for a leading edge at step zero
    task automatic align_frame();
        while (seq_step != 0 || seq_phase != cfg_neg)
            post_edge(pick_span(1'b1));
    endtask

    // Opening edge plus seven channel widths
    task automatic send_frame(input logic well_formed);
        post_edge(TIME_W'($urandom_range(65535, 0)));
        for (int k = 0; k < CHANNELS; k++)
            post_edge(pick_span(well_formed || $urandom_range(3, 0) != 0));
    endtask

    // Ticks until the first timeout, and on to signal loss if asked
    task automatic tick_out(input logic to_loss);
        do post_tick(); while (!gap_armed);
        if (to_loss)
            do post_tick(); while (gap_long);
    endtask

    task automatic run_traffic(input int n);
        int stop_at;
        int pick;
        stop_at = events_posted + n;
        while (events_posted < stop_at)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
            begin
                align_frame();
                send_frame($urandom_range(99, 0) < 80);
                repeat ($urandom_range(3, 0)) post_tick();
            end
            else if (pick < 80)
            begin
                // frame cut short by a gap
                repeat ($urandom_range(7, 1)) post_edge(pick_span(1'b1));
                tick_out(1'b0);
            end
            else if (pick < 88)
                tick_out(1'b1);
            else
            begin
                // noise
                repeat ($urandom_range(6, 1))
                begin
                    if ($urandom_range(1, 0))
                        post_tick();
                    else
                        post_event(CMD_EDGE, TIME_W'($urandom_range(65535, 0)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Width extremes, a wrapping timestamp and raw aux widths
    task automatic test_reference_frame();
        align_frame();
        train_clock = 16'hFE00;
        post_edge(16'h0100);
        post_edge(16'd512);
        post_edge(16'd1023);
        post_edge(16'd1022);
        post_edge(16'd513);
        post_edge(16'd768);
        post_edge(16'd0);
        post_edge(16'hFFFF);
        post_tick();
    endtask

    // Widths just below and just above the valid band
    task automatic test_range_check();
        align_frame();
        post_edge(16'd40);
        post_edge(16'd600);
        post_edge(16'd510);
        post_edge(16'd700);
        post_edge(16'd700);
        post_edge(16'd700);
        post_edge(16'd600);
        post_edge(16'd600);
        align_frame();
        post_edge(16'd40);
        post_edge(16'd1023);
        post_edge(16'd512);
        post_edge(16'd512);
        post_edge(16'd512);
        post_edge(16'd1024);
    endtask

    // Limit lowered under a running count, loss, and both polarity faults
    task automatic test_gap_and_polarity();
        repeat (10) post_tick();
        write_reg(CFG_SHORT_GAP_TICKS, 16'd3);
        post_tick();
        write_reg(CFG_LONG_GAP_TICKS, 16'd2);
        repeat (2) post_tick();
        // timeout after one edge leaves a trailing edge at step zero
        align_frame();
        post_edge(16'd600);
        repeat (3) post_tick();
        post_edge(16'd600);
        // polarity flipped after one edge gives a leading edge at step one
        align_frame();
        post_edge(16'd600);
        write_reg(CFG_NEGATIVE_PULSES, 16'd1);
        post_edge(16'd600);
        write_reg(CFG_NEGATIVE_PULSES, 16'd0);
    endtask

    // Largest gap limits, run back to back at full rate
    task automatic test_gap_limit_extremes();
        full_rate = 1'b1;
        write_reg(CFG_SHORT_GAP_TICKS, 16'hFFFF);
        write_reg(CFG_LONG_GAP_TICKS, 16'd1);
        post_edge(pick_span(1'b1));
        // far short limit: the count runs on with no timeout
        repeat (20) post_tick();
        // short limit dropped under the count, then the one-tick long limit
        write_reg(CFG_SHORT_GAP_TICKS, 16'd1);
        tick_out(1'b1);
        write_reg(CFG_LONG_GAP_TICKS, 16'hFFFF);
        post_edge(pick_span(1'b1));
        // first timeout on the next tick, then a long wait with no loss
        tick_out(1'b0);
        repeat (20) post_tick();
        full_rate = 1'b0;
    endtask

    // Random traffic under each mapping mode, polarity and neutral extreme
    task automatic test_stick_modes();
        apply_settings(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd20, 16'd30);
        run_traffic(130);
        apply_settings(8'd255, 1'b1, 1'b0, 1'b1, 1'b1, 16'd1, 16'd1);
        run_traffic(130);
        apply_settings(8'd128, 1'b1, 1'b1, 1'b0, 1'b0, 16'd40, 16'd65);
        run_traffic(130);
        apply_settings(BYTE_W'($urandom_range(255, 0)), 1'b1, 1'b1, 1'b1, 1'b1,
                       TIME_W'($urandom_range(40, 5)), TIME_W'($urandom_range(60, 5)));
        run_traffic(130);
        apply_settings(BYTE_W'($urandom_range(255, 0)), 1'b0, 1'b1, 1'b1, 1'b0,
                       TIME_W'($urandom_range(30, 2)), TIME_W'($urandom_range(50, 2)));
        run_traffic(130);
        apply_settings(NEUTRAL_RST, 1'b0, 1'b0, 1'b0, 1'b0, SHORT_GAP_RST, LONG_GAP_RST);
        run_traffic(130);
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = draw_wait(1);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid));
            @(negedge clk);
        end
    end

    task automatic check_field(input string field, input logic [CTR_W-1:0] want,
                               input logic [CTR_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endtask

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        stick_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("throttle", CTR_W'(want.throttle), CTR_W'(throttle));
                check_field("roll", want.roll, roll);
                check_field("pitch", want.pitch, pitch);
                check_field("yaw", want.yaw, yaw);
                check_field("aux_five", CTR_W'(want.aux_five), CTR_W'(aux_five));
                check_field("aux_six", CTR_W'(want.aux_six), CTR_W'(aux_six));
                check_field("aux_seven", CTR_W'(want.aux_seven), CTR_W'(aux_seven));
                check_field("signal_lost", CTR_W'(want.signal_lost), CTR_W'(signal_lost));
                check_field("fresh_frame", CTR_W'(want.fresh_frame), CTR_W'(fresh_frame));
            end
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("rc_ppm_channel_decoder regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_EDGE;
        capture_time = '0;
        train_clock  = '0;

        // model at reset
        foreach (pulse_span[i])
            pulse_span[i] = '0;
        seq_step         = '0;
        seq_phase        = 1'b0;
        gap_armed        = 1'b0;
        gap_long         = 1'b0;
        gap_ticks        = '0;
        held             = '0;
        held.signal_lost = 1'b1;
        cfg_neutral      = NEUTRAL_RST;
        cfg_third        = 1'b0;
        cfg_swap         = 1'b0;
        cfg_dbl          = 1'b0;
        cfg_neg          = 1'b0;
        cfg_short        = SHORT_GAP_RST;
        cfg_long         = LONG_GAP_RST;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reference_frame();
        test_range_check();
        test_gap_and_polarity();
        test_gap_limit_extremes();
        test_stick_modes();

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("rc_ppm_channel_decoder regression: pass");
        else
            $display("rc_ppm_channel_decoder regression: fail");
        $finish;
    end

endmodule
